// ===== rtl/gdnc_pkg.sv =====
// gdnc_pkg: widths, calendar constants, pipeline item type and helper functions
// for the gregorian day number converter; no dependencies
`default_nettype none

package gdnc_pkg;

   localparam int MAX_YEAR_DEF = 9999;

   localparam int REQ_YEAR_W = 14;
   localparam int YEAR_W     = 15;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int JD_W       = 23;
   localparam int DN_W       = 25;
   localparam int DOY_W      = 9;

   localparam int N_STAGES = 13;

   localparam int EPOCH_BASE = 1721425;
   localparam logic [DN_W-1:0] FIRST_DN = DN_W'(EPOCH_BASE + 1);

   localparam int DAYS_400 = 146097;
   localparam int DAYS_100 = 36524;
   localparam int DAYS_4   = 1461;
   localparam int DAYS_1   = 365;

   // reciprocals for constant division, quotient taken from the product high bits
   localparam int RECIP_400 = 7349;
   localparam int SH_400    = 30;
   localparam int RECIP_4   = 2870;
   localparam int SH_4      = 22;
   localparam int RECIP_100 = 5243;
   localparam int SH_100    = 19;
   localparam int RECIP_MON = 5715;
   localparam int SH_MON    = 21;

   typedef enum logic {
      DIR_TO_NUMBER = 1'b0,
      DIR_TO_DATE   = 1'b1
   } dir_type;

   typedef struct packed {
      logic                     dir;
      logic                     err;
      logic [YEAR_W-1:0]        year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
      logic [JD_W-1:0]          jd;
      logic [JD_W-1:0]          rem;
      logic [REQ_YEAR_W-1:0]    p;
      logic [8:0]               cent;
      logic [5:0]               n400;
      logic [2:0]               n100;
      logic [4:0]               n4;
      logic [23:0]              prod;
      logic [JD_W-1:0]          ys;
      logic                     leap;
      logic [8:0]               prior;
      logic signed [10:0]       doy;
      logic [12:0]              num;
      logic [DN_W-1:0]          dn;
      logic [DOY_W-1:0]         ord;
   } item_type;

   typedef struct packed {
      logic [N_STAGES-1:0] en;
      logic [N_STAGES-1:0] valid;
   } pipe_ctl_type;

   // days before the first of month m in a common year, formula extended to all codes
   function automatic logic signed [9:0] month_base(input logic [MONTH_W-1:0] m);
      logic signed [9:0] r;
      case (m)
         4'd0:    r = -10'sd31;
         4'd1:    r = 10'sd0;
         4'd2:    r = 10'sd31;
         4'd3:    r = 10'sd59;
         4'd4:    r = 10'sd90;
         4'd5:    r = 10'sd120;
         4'd6:    r = 10'sd151;
         4'd7:    r = 10'sd181;
         4'd8:    r = 10'sd212;
         4'd9:    r = 10'sd243;
         4'd10:   r = 10'sd273;
         4'd11:   r = 10'sd304;
         4'd12:   r = 10'sd334;
         4'd13:   r = 10'sd365;
         4'd14:   r = 10'sd396;
         default: r = 10'sd426;
      endcase
      return r;
   endfunction

   // day number of december 31 of the given year
   function automatic int last_day_number(input int max_year);
      int p;
      int ly;
      p  = max_year - 1;
      ly = ((max_year % 4 == 0) && ((max_year % 100 != 0) || (max_year % 400 == 0))) ? 1 : 0;
      return EPOCH_BASE + 365 * p + p / 4 - p / 100 + p / 400 + 365 + ly;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gdnc_req_if.sv =====
// gdnc_req_if: request channel, valid/ready with one conversion request
// depends on gdnc_pkg
`default_nettype none

interface gdnc_req_if import gdnc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [REQ_YEAR_W-1:0]   in_year;
   logic [MONTH_W-1:0]      in_month;
   logic [DAY_W-1:0]        in_day;
   logic [JD_W-1:0]         in_day_number;

   modport source (
      output valid, req_type, in_year, in_month, in_day, in_day_number,
      input  ready
   );

   modport sink (
      input  valid, req_type, in_year, in_month, in_day, in_day_number,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/gdnc_rsp_if.sv =====
// gdnc_rsp_if: response channel, valid/ready with one converted date
// depends on gdnc_pkg
`default_nettype none

interface gdnc_rsp_if import gdnc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [JD_W-1:0]         day_number;
   logic [REQ_YEAR_W-1:0]   out_year;
   logic [MONTH_W-1:0]      out_month;
   logic [DAY_W-1:0]        out_day;
   logic [DOY_W-1:0]        day_of_year;
   logic                    is_leap;
   logic                    range_error;

   modport source (
      output valid, day_number, out_year, out_month, out_day, day_of_year, is_leap,
             range_error,
      input  ready
   );

   modport sink (
      input  valid, day_number, out_year, out_month, out_day, day_of_year, is_leap,
             range_error,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/gregorian_day_number_converter.sv =====
// Converts a proleptic Gregorian date to a whole day number (0001-01-01 = 1721426) or a
// day number back to a date, chosen per transfer by req_type. Thirteen register stages,
// one transfer per cycle sustained while the response is taken; each stage holds its item
// while the one after it is full and does not load, so a stalled response costs no items
// already in flight and empty stages still fill. The stage depth is set by the divider chain of
// the day-number direction (by 146097 and 1461 as reciprocal multiplies with one
// correction each, by 36524 and 365 as compare chains) followed by the leap test and the
// month lookup. A year of 0 or
// beyond MAX_YEAR, or a day number outside 0001-01-01 .. MAX_YEAR-12-31, returns
// range_error with every other field zero. Month and day are not checked.
// depends on gdnc_pkg, gdnc_req_if, gdnc_rsp_if, gdnc_pipe_ctl
`default_nettype none

module gregorian_day_number_converter import gdnc_pkg::*; #(
   parameter int MAX_YEAR = MAX_YEAR_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   gdnc_req_if.sink  req_ch,
   gdnc_rsp_if.source rsp_ch
);

   localparam logic [DN_W-1:0] LAST_DN = DN_W'(last_day_number(MAX_YEAR));

   pipe_ctl_type ctl;
   item_type     st_ff [N_STAGES];
   item_type     st_in [N_STAGES];

   logic [35:0]        s1_prod;
   logic [27:0]        s1_cprod;
   logic [23:0]        s3_r0;
   logic [23:0]        s3_r1;
   logic               s3_fix;
   logic [17:0]        s4_d1;
   logic [17:0]        s4_sub;
   logic [2:0]         s4_n100;
   logic [27:0]        s5_prod;
   logic [15:0]        s6_r0;
   logic [15:0]        s6_r1;
   logic               s6_fix;
   logic [10:0]        s7_d3;
   logic [10:0]        s7_sub;
   logic [10:0]        s7_rem;
   logic [2:0]         s7_n1;
   logic               s7_last;
   logic [YEAR_W-1:0]  s7_y;
   logic [27:0]        s8_prod;
   logic [15:0]        s9_hund;
   logic signed [9:0]  s10_mb;
   logic               s10_adj;
   logic [1:0]         s10_corr;
   logic [25:0]        s11_prod;
   logic signed [9:0]  s12_mb;
   logic               s12_adj;
   logic [9:0]         s12_day;

   gdnc_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   // request capture, range check and offset from the first day
   always_comb begin
      st_in[0]       = '0;
      st_in[0].dir   = req_ch.req_type;
      st_in[0].year  = {1'b0, req_ch.in_year};
      st_in[0].month = req_ch.in_month;
      st_in[0].day   = req_ch.in_day;
      st_in[0].jd    = req_ch.in_day_number;
      st_in[0].p     = req_ch.in_year - REQ_YEAR_W'(1);
      st_in[0].rem   = req_ch.in_day_number - JD_W'(FIRST_DN);
      if (req_ch.req_type == DIR_TO_DATE) begin
         st_in[0].err = ({2'b0, req_ch.in_day_number} < FIRST_DN) ||
                        ({2'b0, req_ch.in_day_number} > LAST_DN);
      end else begin
         st_in[0].err = (req_ch.in_year == '0) ||
                        ({3'b0, req_ch.in_year} > 17'(MAX_YEAR));
      end
   end

   // 400-year estimate, centuries before the year
   always_comb begin
      s1_prod       = 36'(st_ff[0].rem) * 36'(RECIP_400);
      s1_cprod      = 28'(st_ff[0].p) * 28'(RECIP_100);
      st_in[1]      = st_ff[0];
      st_in[1].n400 = s1_prod[SH_400 +: 6];
      st_in[1].cent = s1_cprod[SH_100 +: 9];
   end

   // days in whole 400-year blocks, days before january 1
   always_comb begin
      st_in[2]      = st_ff[1];
      st_in[2].prod = 24'(st_ff[1].n400) * 24'(DAYS_400);
      st_in[2].ys   = 23'(st_ff[1].p) * 23'(DAYS_1) + 23'(st_ff[1].p[REQ_YEAR_W-1:2])
                    - 23'(st_ff[1].cent) + 23'(st_ff[1].cent[8:2]);
   end

   // 400-year remainder with correction
   always_comb begin
      s3_r0         = {1'b0, st_ff[2].rem} - st_ff[2].prod;
      s3_r1         = s3_r0 - 24'(DAYS_400);
      s3_fix        = s3_r0 >= 24'(DAYS_400);
      st_in[3]      = st_ff[2];
      st_in[3].rem  = s3_fix ? s3_r1[JD_W-1:0] : s3_r0[JD_W-1:0];
      st_in[3].n400 = st_ff[2].n400 + 6'(s3_fix);
   end

   // centuries within the block, the last day of the block counts as a fourth
   always_comb begin
      s4_d1 = st_ff[3].rem[17:0];
      if (s4_d1 >= 18'(4 * DAYS_100)) begin
         s4_n100 = 3'd4;
         s4_sub  = 18'(4 * DAYS_100);
      end else if (s4_d1 >= 18'(3 * DAYS_100)) begin
         s4_n100 = 3'd3;
         s4_sub  = 18'(3 * DAYS_100);
      end else if (s4_d1 >= 18'(2 * DAYS_100)) begin
         s4_n100 = 3'd2;
         s4_sub  = 18'(2 * DAYS_100);
      end else if (s4_d1 >= 18'(DAYS_100)) begin
         s4_n100 = 3'd1;
         s4_sub  = 18'(DAYS_100);
      end else begin
         s4_n100 = 3'd0;
         s4_sub  = '0;
      end
      st_in[3+1]      = st_ff[3];
      st_in[3+1].n100 = s4_n100;
      st_in[3+1].rem  = JD_W'(s4_d1 - s4_sub);
   end

   // 4-year estimate
   always_comb begin
      s5_prod     = 28'(st_ff[4].rem[15:0]) * 28'(RECIP_4);
      st_in[5]    = st_ff[4];
      st_in[5].n4 = s5_prod[SH_4 +: 5];
   end

   // 4-year remainder with correction
   always_comb begin
      s6_r0        = st_ff[5].rem[15:0] - 16'(16'(st_ff[5].n4) * 16'(DAYS_4));
      s6_r1        = s6_r0 - 16'(DAYS_4);
      s6_fix       = s6_r0 >= 16'(DAYS_4);
      st_in[6]     = st_ff[5];
      st_in[6].rem = JD_W'(s6_fix ? s6_r1 : s6_r0);
      st_in[6].n4  = st_ff[5].n4 + 5'(s6_fix);
   end

   // single years, year assembly and days before the date within its year
   always_comb begin
      s7_d3 = st_ff[6].rem[10:0];
      if (s7_d3 >= 11'(4 * DAYS_1)) begin
         s7_n1  = 3'd4;
         s7_sub = 11'(4 * DAYS_1);
      end else if (s7_d3 >= 11'(3 * DAYS_1)) begin
         s7_n1  = 3'd3;
         s7_sub = 11'(3 * DAYS_1);
      end else if (s7_d3 >= 11'(2 * DAYS_1)) begin
         s7_n1  = 3'd2;
         s7_sub = 11'(2 * DAYS_1);
      end else if (s7_d3 >= 11'(DAYS_1)) begin
         s7_n1  = 3'd1;
         s7_sub = 11'(DAYS_1);
      end else begin
         s7_n1  = 3'd0;
         s7_sub = '0;
      end
      s7_rem  = s7_d3 - s7_sub;
      s7_last = (st_ff[6].n100 == 3'd4) || (s7_n1 == 3'd4);
      s7_y    = YEAR_W'(st_ff[6].n400) * YEAR_W'(400) + YEAR_W'(st_ff[6].n100) * YEAR_W'(100)
              + YEAR_W'({st_ff[6].n4, 2'b00}) + YEAR_W'(s7_n1) + {14'b0, ~s7_last};
      st_in[7] = st_ff[6];
      if (st_ff[6].dir == DIR_TO_DATE) begin
         st_in[7].year  = s7_y;
         st_in[7].prior = s7_last ? 9'(DAYS_1) : s7_rem[8:0];
      end
   end

   // century of the year
   always_comb begin
      s8_prod       = 28'(st_ff[7].year) * 28'(RECIP_100);
      st_in[8]      = st_ff[7];
      st_in[8].cent = s8_prod[SH_100 +: 9];
   end

   // leap year
   always_comb begin
      s9_hund       = 16'(st_ff[8].cent) * 16'd100;
      st_in[9]      = st_ff[8];
      st_in[9].leap = (st_ff[8].year[1:0] == 2'b00) &&
                      (({1'b0, st_ff[8].year} != s9_hund) || (st_ff[8].cent[1:0] == 2'b00));
   end

   // ordinal day of the date, month numerator of the day number
   always_comb begin
      s10_mb   = month_base(st_ff[9].month);
      s10_adj  = st_ff[9].leap && (st_ff[9].month > 4'd2);
      s10_corr = (st_ff[9].prior < (st_ff[9].leap ? 9'd60 : 9'd59)) ? 2'd0 :
                 (st_ff[9].leap ? 2'd1 : 2'd2);
      st_in[10]     = st_ff[9];
      st_in[10].doy = {s10_mb[9], s10_mb} + 11'(s10_adj) + 11'(st_ff[9].day);
      st_in[10].num = 13'(10'(st_ff[9].prior) + 10'(s10_corr)) * 13'd12 + 13'd373;
   end

   // day number of the date, month of the day number
   always_comb begin
      s11_prod     = 26'(st_ff[10].num) * 26'(RECIP_MON);
      st_in[11]    = st_ff[10];
      st_in[11].dn = DN_W'(EPOCH_BASE) + DN_W'(st_ff[10].ys)
                   + {{(DN_W-11){st_ff[10].doy[10]}}, st_ff[10].doy};
      if (st_ff[10].dir == DIR_TO_DATE) begin
         st_in[11].month = s11_prod[SH_MON +: MONTH_W];
      end
   end

   // day of month and result assembly
   always_comb begin
      s12_mb    = month_base(st_ff[11].month);
      s12_adj   = st_ff[11].leap && (st_ff[11].month > 4'd2);
      s12_day   = 10'(st_ff[11].prior) + 10'd1 - s12_mb - 10'(s12_adj);
      st_in[12] = st_ff[11];
      if (st_ff[11].err) begin
         st_in[12].dn    = '0;
         st_in[12].year  = '0;
         st_in[12].month = '0;
         st_in[12].day   = '0;
         st_in[12].ord   = '0;
         st_in[12].leap  = 1'b0;
      end else if (st_ff[11].dir == DIR_TO_DATE) begin
         st_in[12].dn  = DN_W'(st_ff[11].jd);
         st_in[12].day = s12_day[DAY_W-1:0];
         st_in[12].ord = st_ff[11].prior + 9'd1;
      end else begin
         st_in[12].ord = st_ff[11].doy[DOY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N_STAGES; k++) begin
         if (ctl.en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign rsp_ch.valid       = ctl.valid[N_STAGES-1];
   assign rsp_ch.day_number  = st_ff[N_STAGES-1].dn[JD_W-1:0];
   assign rsp_ch.out_year    = st_ff[N_STAGES-1].year[REQ_YEAR_W-1:0];
   assign rsp_ch.out_month   = st_ff[N_STAGES-1].month;
   assign rsp_ch.out_day     = st_ff[N_STAGES-1].day;
   assign rsp_ch.day_of_year = st_ff[N_STAGES-1].ord;
   assign rsp_ch.is_leap     = st_ff[N_STAGES-1].leap;
   assign rsp_ch.range_error = st_ff[N_STAGES-1].err;

`ifndef NO_ASSERTIONS
   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.range_error |->
         rsp_ch.day_number == '0 && rsp_ch.out_year == '0 && rsp_ch.out_month == '0 &&
         rsp_ch.out_day == '0 && rsp_ch.day_of_year == '0 && !rsp_ch.is_leap)
      else $error("range error response with non-zero fields");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.range_error && st_ff[N_STAGES-1].dir == DIR_TO_DATE |->
         rsp_ch.out_month >= 4'd1 && rsp_ch.out_month <= 4'd12 &&
         rsp_ch.out_day >= 5'd1 && rsp_ch.day_of_year >= 9'd1 &&
         rsp_ch.day_of_year <= 9'd366)
      else $error("decoded date outside calendar range");

   a_leap_div4: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_leap |-> rsp_ch.out_year[1:0] == 2'b00)
      else $error("leap flag on a year not divisible by four");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      ctl.valid[N_STAGES-1] && !rsp_ch.ready |=> ctl.valid[N_STAGES-1] && !ctl.en[0] ||
         ctl.valid[N_STAGES-1])
      else $error("stalled response stage lost its item");
`endif

endmodule

`default_nettype wire

// ===== rtl/gdnc_pipe_ctl.sv =====
// gdnc_pipe_ctl: valid bits and per-stage load enables for the converter pipeline,
// a stage loads when empty or when the stage after it loads; depends on gdnc_pkg
`default_nettype none

module gdnc_pipe_ctl import gdnc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire logic    out_ready,
   output pipe_ctl_type ctl
);

   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES-1:0] valid_in;
   logic [N_STAGES-1:0] en;

   assign en[N_STAGES-1] = !valid_ff[N_STAGES-1] || out_ready;

   for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_en
      assign en[k] = !valid_ff[k] || en[k+1];
   end

   assign valid_in = (en & {valid_ff[N_STAGES-2:0], in_valid}) | (~en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = en[0];
   assign ctl.en    = en;
   assign ctl.valid = valid_ff;

endmodule

`default_nettype wire

// ===== bench/tb_gregorian_day_number_converter.sv =====
// testbench for gregorian_day_number_converter: directed and random conversions in both
// directions, checked against an in-bench calendar predictor under random stalls
// depends on gdnc_pkg, gdnc_req_if, gdnc_rsp_if and the converter rtl
`timescale 1ns / 1ps

module tb_gregorian_day_number_converter import gdnc_pkg::*; ();

   localparam int     LAST_YEAR    = 9999;
   localparam longint DAY_BASE     = 1721425;
   localparam int     RANDOM_ITEMS = 1800;
   localparam int     TIMEOUT_NS   = 5000000;

   typedef struct packed {
      dir_type                 kind;
      logic [REQ_YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]      month;
      logic [DAY_W-1:0]        day;
      logic [JD_W-1:0]         day_number;
   } request_type;

   typedef struct {
      request_type req;
      bit          wait_idle;
   } pending_type;

   typedef struct packed {
      logic [JD_W-1:0]         day_number;
      logic [REQ_YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]      month;
      logic [DAY_W-1:0]        day;
      logic [DOY_W-1:0]        doy;
      logic                    leap;
      logic                    range_error;
   } date_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gdnc_req_if req_ch ();
   gdnc_rsp_if rsp_ch ();

   gregorian_day_number_converter #(
      .MAX_YEAR(LAST_YEAR)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pending_type     conversion_queue[$];
   date_result_type expected_dates[$];

   int  errors            = 0;
   int  requests_queued   = 0;
   int  requests_accepted = 0;
   logic req_taken        = 1'b0;
   logic rsp_taken        = 1'b0;
   int  send_gap          = 0;
   bit  send_burst        = 1'b0;
   int  recv_wait         = 0;
   bit  recv_burst        = 1'b0;
   int  long_hold         = 0;
   bit  long_hold_done    = 1'b0;

   always #6 clock = ~clock;

   function automatic bit is_leap_year(input longint y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic longint days_before_year(input longint y);
      longint p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   // month term is floored, so month 0 lands before january
   function automatic longint day_in_year(input longint y, input longint m, input longint d);
      longint t;
      longint r;
      t = 367 * m - 362;
      r = (t >= 0) ? t / 12 : -((11 - t) / 12);
      if (m > 2) r -= is_leap_year(y) ? 1 : 2;
      return r + d;
   endfunction

   function automatic longint date_to_day_number(input longint y, input longint m,
                                                 input longint d);
      return DAY_BASE + days_before_year(y) + day_in_year(y, m, d);
   endfunction

   function automatic date_result_type convert_date(input request_type rq);
      date_result_type res;
      longint y, m, d, jd, doy, d0, d1, d2, d3, n400, n100, n4, n1, prior, corr;
      res = '0;
      if (rq.kind == DIR_TO_NUMBER) begin
         y = rq.year;
         m = rq.month;
         d = rq.day;
         if (y < 1 || y > LAST_YEAR) begin
            res.range_error = 1'b1;
         end else begin
            doy            = day_in_year(y, m, d);
            res.day_number = JD_W'(DAY_BASE + days_before_year(y) + doy);
            res.year       = REQ_YEAR_W'(y);
            res.month      = rq.month;
            res.day        = rq.day;
            res.doy        = DOY_W'(doy);
            res.leap       = is_leap_year(y);
         end
      end else begin
         jd = rq.day_number;
         if (jd < DAY_BASE + 1 || jd > date_to_day_number(LAST_YEAR, 12, 31)) begin
            res.range_error = 1'b1;
         end else begin
            d0   = jd - DAY_BASE - 1;
            n400 = d0 / 146097;
            d1   = d0 % 146097;
            n100 = d1 / 36524;
            d2   = d1 % 36524;
            n4   = d2 / 1461;
            d3   = d2 % 1461;
            n1   = d3 / 365;
            y    = 400 * n400 + 100 * n100 + 4 * n4 + n1;
            // last day of a four-year or four-century cycle stays in the year counted
            if (!(n100 == 4 || n1 == 4)) y += 1;
            prior = jd - date_to_day_number(y, 1, 1);
            if (jd < date_to_day_number(y, 3, 1)) corr = 0;
            else corr = is_leap_year(y) ? 1 : 2;
            m = (12 * (prior + corr) + 373) / 367;
            d = jd - date_to_day_number(y, m, 1) + 1;
            res.day_number = JD_W'(jd);
            res.year       = REQ_YEAR_W'(y);
            res.month      = MONTH_W'(m);
            res.day        = DAY_W'(d);
            res.doy        = DOY_W'(prior + 1);
            res.leap       = is_leap_year(y);
         end
      end
      return res;
   endfunction

   // fields not used by the direction are filled with noise
   task automatic add_request(input dir_type kind, input longint y, input longint m,
                              input longint d, input longint jd, input bit wait_idle);
      pending_type item;
      item.req.kind       = kind;
      item.req.year       = (kind == DIR_TO_NUMBER) ? REQ_YEAR_W'(y) : REQ_YEAR_W'($urandom);
      item.req.month      = (kind == DIR_TO_NUMBER) ? MONTH_W'(m) : MONTH_W'($urandom);
      item.req.day        = (kind == DIR_TO_NUMBER) ? DAY_W'(d) : DAY_W'($urandom);
      item.req.day_number = (kind == DIR_TO_DATE) ? JD_W'(jd) : JD_W'($urandom);
      item.wait_idle      = wait_idle;
      conversion_queue.push_back(item);
      requests_queued++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.req_type      <= 1'b0;
         req_ch.in_year       <= '0;
         req_ch.in_month      <= '0;
         req_ch.in_day        <= '0;
         req_ch.in_day_number <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap--;
         end else if (conversion_queue.size() != 0 &&
                      (!conversion_queue[0].wait_idle || expected_dates.size() == 0)) begin
            req_ch.valid         <= 1'b1;
            req_ch.req_type      <= conversion_queue[0].req.kind;
            req_ch.in_year       <= conversion_queue[0].req.year;
            req_ch.in_month      <= conversion_queue[0].req.month;
            req_ch.in_day        <= conversion_queue[0].req.day;
            req_ch.in_day_number <= conversion_queue[0].req.day_number;
            void'(conversion_queue.pop_front());
            if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 8);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response sink, with one long hold-off to back the pipeline up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, 8);
         end
         if (!long_hold_done && requests_accepted >= 700) begin
            long_hold      = 120;
            long_hold_done = 1'b1;
         end
         if (long_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            long_hold--;
         end else if (recv_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin : check_results
      request_type     rq;
      date_result_type want;
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            rq.kind       = dir_type'(req_ch.req_type);
            rq.year       = req_ch.in_year;
            rq.month      = req_ch.in_month;
            rq.day        = req_ch.in_day;
            rq.day_number = req_ch.in_day_number;
            expected_dates.push_back(convert_date(rq));
            requests_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_dates.size() == 0) begin
               $display("%0t: response with nothing outstanding, day_number %0d",
                        $time, rsp_ch.day_number);
               errors++;
            end else begin
               want = expected_dates.pop_front();
               check_field("day_number", 32'(want.day_number), 32'(rsp_ch.day_number));
               check_field("out_year", 32'(want.year), 32'(rsp_ch.out_year));
               check_field("out_month", 32'(want.month), 32'(rsp_ch.out_month));
               check_field("out_day", 32'(want.day), 32'(rsp_ch.out_day));
               check_field("day_of_year", 32'(want.doy), 32'(rsp_ch.day_of_year));
               check_field("is_leap", 32'(want.leap), 32'(rsp_ch.is_leap));
               check_field("range_error", 32'(want.range_error), 32'(rsp_ch.range_error));
            end
         end
      end
   end

   initial begin
      longint last_day;
      longint y;
      int     i;
      int     r;
      bit     hold_for_idle;

      last_day = date_to_day_number(LAST_YEAR, 12, 31);

      // date to day number: span edges, out of span years, leap rules, unchecked fields
      add_request(DIR_TO_NUMBER, 1, 1, 1, 0, 1'b0);
      add_request(DIR_TO_NUMBER, LAST_YEAR, 12, 31, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 0, 6, 15, 0, 1'b0);
      add_request(DIR_TO_NUMBER, LAST_YEAR + 1, 1, 1, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 16383, 15, 31, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 2000, 2, 29, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 1900, 3, 1, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 2024, 12, 31, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 2001, 0, 0, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 2023, 13, 5, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 2000, 14, 0, 0, 1'b0);
      add_request(DIR_TO_NUMBER, 2023, 15, 31, 0, 1'b0);

      // day number to date: span edges, all ones, cycle ends, february boundaries
      add_request(DIR_TO_DATE, 0, 0, 0, DAY_BASE + 1, 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, DAY_BASE, 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, 0, 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, last_day, 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, last_day + 1, 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, (1 << JD_W) - 1, 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, date_to_day_number(2000, 12, 31), 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, date_to_day_number(2004, 12, 31), 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, date_to_day_number(2000, 2, 29), 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, date_to_day_number(2000, 3, 1), 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, date_to_day_number(1900, 2, 28), 1'b0);
      add_request(DIR_TO_DATE, 0, 0, 0, date_to_day_number(1900, 3, 1), 1'b0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         r             = $urandom_range(0, 99);
         y             = $urandom_range(1, LAST_YEAR);
         hold_for_idle = (i == 0) || (i == RANDOM_ITEMS / 2);
         if ($urandom_range(0, 1) == 0) begin
            if (r < 70)
               add_request(DIR_TO_NUMBER, y, $urandom_range(1, 12), $urandom_range(1, 31),
                           0, hold_for_idle);
            else if (r < 85)
               add_request(DIR_TO_NUMBER, 100 * $urandom_range(0, 99) + $urandom_range(0, 4),
                           $urandom_range(2, 3), $urandom_range(28, 31), 0, hold_for_idle);
            else
               add_request(DIR_TO_NUMBER, $urandom_range(0, 16383), $urandom_range(0, 15),
                           $urandom_range(0, 31), 0, hold_for_idle);
         end else begin
            if (r < 70)
               add_request(DIR_TO_DATE, 0, 0, 0, $urandom_range(DAY_BASE + 1, last_day),
                           hold_for_idle);
            else if (r < 85)
               add_request(DIR_TO_DATE, 0, 0, 0,
                           date_to_day_number(y, $urandom_range(1, 12), 1)
                           - $urandom_range(0, 1), hold_for_idle);
            else
               add_request(DIR_TO_DATE, 0, 0, 0, $urandom_range(0, (1 << JD_W) - 1),
                           hold_for_idle);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (conversion_queue.size() != 0 || requests_accepted != requests_queued ||
             expected_dates.size() != 0)
         @(negedge clock);
      repeat (N_STAGES + 10) @(negedge clock);

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("FAILURE");
      $finish;
   end

endmodule
